### src/vn4_pkg.sv
// Package for the 4D value noise block: sizes, item type and sequencer states.
// No dependencies. Used by vn4_front, vn4_back and value_noise_4d.
`timescale 1ns / 1ps
`default_nettype none
package vn4_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int IDX_W      = 8;
  localparam int FRAC_BITS  = 16;
  localparam int VALUE_BITS = 16;
  localparam int COORD_W    = 32;
  localparam int TIME_W     = 48;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;
  localparam int PROD_W     = FRAC_BITS + VALUE_BITS + 2;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic                         query;
    logic [IDX_W-1:0]             idx;
    logic [IDX_W-1:0]             perm;
    logic signed [VALUE_BITS-1:0] noise;
    logic [IDX_W-1:0]             ix;
    logic [IDX_W-1:0]             iy;
    logic [IDX_W-1:0]             iz;
    logic [IDX_W-1:0]             it;
    logic [FRAC_BITS-1:0]         fx;
    logic [FRAC_BITS-1:0]         fy;
    logic [FRAC_BITS-1:0]         fz;
    logic [FRAC_BITS-1:0]         ft;
  } vn4_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PT,
    ST_PZ,
    ST_PY,
    ST_PX,
    ST_NV,
    ST_NW,
    ST_MRG,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } vn4_state_t;

endpackage
`default_nettype wire

### src/vn4_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module vn4_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### src/vn4_front.sv
// Front end: accepts requests, splits coordinates into cell and fraction, queues them.
// Depends on vn4_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vn4_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              action,
  input  wire logic [vn4_pkg::IDX_W-1:0]         load_index,
  input  wire logic signed [vn4_pkg::VALUE_BITS-1:0] load_noise,
  input  wire logic [vn4_pkg::IDX_W-1:0]         load_perm,
  input  wire logic signed [vn4_pkg::COORD_W-1:0] coord_x,
  input  wire logic signed [vn4_pkg::COORD_W-1:0] coord_y,
  input  wire logic signed [vn4_pkg::COORD_W-1:0] coord_z,
  input  wire logic signed [vn4_pkg::TIME_W-1:0]  coord_t,
  output vn4_pkg::vn4_item_t                     q_item,
  output logic                                   q_valid,
  input  wire logic                              q_pop
);
  import vn4_pkg::*;

  vn4_item_t         slots [QDEPTH];
  vn4_item_t         item_in;
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;

  // The cell index keeps only its low bits, so floor and wrap come for free.
  always_comb begin
    item_in.query = action;
    item_in.idx   = load_index;
    item_in.perm  = load_perm;
    item_in.noise = load_noise;
    item_in.ix    = coord_x[FRAC_BITS +: IDX_W];
    item_in.iy    = coord_y[FRAC_BITS +: IDX_W];
    item_in.iz    = coord_z[FRAC_BITS +: IDX_W];
    item_in.it    = coord_t[FRAC_BITS +: IDX_W];
    item_in.fx    = coord_x[FRAC_BITS-1:0];
    item_in.fy    = coord_y[FRAC_BITS-1:0];
    item_in.fz    = coord_z[FRAC_BITS-1:0];
    item_in.ft    = coord_t[FRAC_BITS-1:0];
  end

  assign in_stall = (count == (QPTR_W+1)'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item_in;
    end
  end

endmodule
`default_nettype wire

### src/vn4_back.sv
// Back end: table writes and the query sequencer (hash chain, shared interpolator).
// Depends on vn4_pkg and vn4_ram.
`timescale 1ns / 1ps
`default_nettype none
module vn4_back (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire vn4_pkg::vn4_item_t                    q_item,
  input  wire logic                                  q_valid,
  output logic                                       q_pop,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [vn4_pkg::VALUE_BITS-1:0]      noise_out
);
  import vn4_pkg::*;

  vn4_state_t                   state;
  vn4_state_t                   state_next;
  vn4_item_t                    cur_item;
  logic [3:0]                   corner;
  logic [2:0]                   lv;
  logic signed [VALUE_BITS-1:0] cur;
  logic signed [VALUE_BITS-1:0] hold [4];
  logic signed [PROD_W-1:0]     prod;
  logic [FRAC_BITS-1:0]         f_sel;
  logic signed [VALUE_BITS:0]   diff;
  logic signed [VALUE_BITS:0]   sum;
  logic                         out_free;
  logic                         tbl_we;
  logic [IDX_W-1:0]             perm_raddr;
  logic [IDX_W-1:0]             pdata;
  logic [VALUE_BITS-1:0]        ndata;

  vn4_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_SIZE)) u_perm (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (q_item.idx),
    .wdata (q_item.perm),
    .raddr (perm_raddr),
    .rdata (pdata)
  );

  vn4_ram #(.WIDTH(VALUE_BITS), .DEPTH(TABLE_SIZE)) u_noise (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (q_item.idx),
    .wdata (q_item.noise),
    .raddr (pdata),
    .rdata (ndata)
  );

  assign out_free = !out_valid || !out_stall;
  assign q_pop    = (state == ST_IDLE);
  assign tbl_we   = (state == ST_IDLE) && q_valid && (q_item.query == ACT_LOAD);
  assign diff     = {cur[VALUE_BITS-1], cur} - {hold[lv[1:0]][VALUE_BITS-1], hold[lv[1:0]]};
  // Arithmetic shift of the product rounds toward minus infinity.
  assign sum      = {hold[lv[1:0]][VALUE_BITS-1], hold[lv[1:0]]}
                  + prod[FRAC_BITS +: VALUE_BITS+1];

  always_comb begin
    case (lv[1:0])
      2'd0:    f_sel = cur_item.fx;
      2'd1:    f_sel = cur_item.fy;
      2'd2:    f_sel = cur_item.fz;
      default: f_sel = cur_item.ft;
    endcase
  end

  // Each corner walks the hash chain t, z, y, x; the RAM read data feeds the next address.
  always_comb begin
    state_next = state;
    perm_raddr = cur_item.it + {{(IDX_W-1){1'b0}}, corner[3]};
    case (state)
      ST_IDLE: begin
        if (q_valid && q_item.query == ACT_QUERY) begin
          state_next = ST_PT;
        end
      end
      ST_PT: state_next = ST_PZ;
      ST_PZ: begin
        perm_raddr = cur_item.iz + {{(IDX_W-1){1'b0}}, corner[2]} + pdata;
        state_next = ST_PY;
      end
      ST_PY: begin
        perm_raddr = cur_item.iy + {{(IDX_W-1){1'b0}}, corner[1]} + pdata;
        state_next = ST_PX;
      end
      ST_PX: begin
        perm_raddr = cur_item.ix + {{(IDX_W-1){1'b0}}, corner[0]} + pdata;
        state_next = ST_NV;
      end
      ST_NV: state_next = ST_NW;
      ST_NW: state_next = ST_MRG;
      ST_MRG: begin
        if (lv == 3'd4) begin
          state_next = ST_DONE;
        end else if (!corner[lv[1:0]]) begin
          state_next = ST_PT;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: state_next = ST_ADD;
      ST_ADD: state_next = ST_MRG;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur_item <= q_item;
        corner   <= '0;
      end
      ST_NW: begin
        cur <= ndata;
        lv  <= '0;
      end
      ST_MRG: begin
        if (lv != 3'd4 && !corner[lv[1:0]]) begin
          hold[lv[1:0]] <= cur;
          corner        <= corner + 1'b1;
        end
      end
      ST_MUL: prod <= PROD_W'($signed({1'b0, f_sel})) * PROD_W'(diff);
      ST_ADD: begin
        cur <= sum[VALUE_BITS-1:0];
        lv  <= lv + 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          noise_out <= cur;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### src/value_noise_4d.sv
// Four-dimensional lattice value noise. A load request (action 0) writes one entry of
// the permutation and noise tables and gives no result. A query request (action 1)
// gives one Q1.15 result: each of the 16 lattice corners takes a chain of dependent
// reads through the single-read permutation RAM and the noise RAM, and each of the
// 15 blends goes through the one shared interpolator. A four-entry queue takes
// requests while a query runs.
// Depends on vn4_pkg, vn4_front and vn4_back.
`timescale 1ns / 1ps
`default_nettype none
module value_noise_4d (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic                                  action,
  input  wire logic [vn4_pkg::IDX_W-1:0]             load_index,
  input  wire logic signed [vn4_pkg::VALUE_BITS-1:0] load_noise,
  input  wire logic [vn4_pkg::IDX_W-1:0]             load_perm,
  input  wire logic signed [vn4_pkg::COORD_W-1:0]    coord_x,
  input  wire logic signed [vn4_pkg::COORD_W-1:0]    coord_y,
  input  wire logic signed [vn4_pkg::COORD_W-1:0]    coord_z,
  input  wire logic signed [vn4_pkg::TIME_W-1:0]     coord_t,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [vn4_pkg::VALUE_BITS-1:0]      noise_out
);
  import vn4_pkg::*;

  vn4_item_t q_item;
  logic      q_valid;
  logic      q_pop;

  vn4_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .load_index (load_index),
    .load_noise (load_noise),
    .load_perm  (load_perm),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .coord_z    (coord_z),
    .coord_t    (coord_t),
    .q_item     (q_item),
    .q_valid    (q_valid),
    .q_pop      (q_pop)
  );

  vn4_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .noise_out (noise_out)
  );

endmodule
`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for the 4D lattice value noise block.
// Depends on vn4_pkg and value_noise_4d; keeps its own copy of both tables.
`timescale 1ns / 1ps
module tb_top;
  import vn4_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = ACT_LOAD;
  logic [IDX_W-1:0] load_index = '0;
  logic signed [VALUE_BITS-1:0] load_noise = '0;
  logic [IDX_W-1:0] load_perm = '0;
  logic signed [COORD_W-1:0] coord_x = '0;
  logic signed [COORD_W-1:0] coord_y = '0;
  logic signed [COORD_W-1:0] coord_z = '0;
  logic signed [TIME_W-1:0] coord_t = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [VALUE_BITS-1:0] noise_out;

  logic signed [VALUE_BITS-1:0] noise_tbl [TABLE_SIZE];
  logic [IDX_W-1:0] perm_tbl [TABLE_SIZE];
  logic signed [VALUE_BITS-1:0] noise_due [$];
  int errors = 0;
  int n_queries = 0;
  int n_loads = 0;
  int n_results = 0;
  bit stall_free = 1'b0;

  value_noise_4d u_dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [IDX_W-1:0] hash4(logic [IDX_W-1:0] x, logic [IDX_W-1:0] y,
                                             logic [IDX_W-1:0] z, logic [IDX_W-1:0] t);
    logic [IDX_W-1:0] h;
    h = perm_tbl[t];
    h = perm_tbl[IDX_W'(z + h)];
    h = perm_tbl[IDX_W'(y + h)];
    h = perm_tbl[IDX_W'(x + h)];
    return h;
  endfunction

  // Arithmetic shift of the product floors toward minus infinity.
  function automatic longint blend(longint a, longint b, longint f);
    return a + ((f * (b - a)) >>> FRAC_BITS);
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] noise_at(logic [COORD_W-1:0] cx,
      logic [COORD_W-1:0] cy, logic [COORD_W-1:0] cz, logic [TIME_W-1:0] ct);
    logic [IDX_W-1:0] ix, iy, iz, it, tt;
    longint fx, fy, fz, ft, f0, f1, b0, b1;
    longint c [2][2][2];
    longint v [2];
    ix = cx[FRAC_BITS +: IDX_W];
    iy = cy[FRAC_BITS +: IDX_W];
    iz = cz[FRAC_BITS +: IDX_W];
    it = ct[FRAC_BITS +: IDX_W];
    fx = cx[FRAC_BITS-1:0];
    fy = cy[FRAC_BITS-1:0];
    fz = cz[FRAC_BITS-1:0];
    ft = ct[FRAC_BITS-1:0];
    for (int i = 0; i < 2; i++) begin
      tt = it + IDX_W'(i);
      for (int a = 0; a < 2; a++)
        for (int b = 0; b < 2; b++)
          for (int d = 0; d < 2; d++)
            c[a][b][d] = noise_tbl[hash4(ix + IDX_W'(a), iy + IDX_W'(b), iz + IDX_W'(d), tt)];
      f0 = blend(c[0][0][0], c[1][0][0], fx);
      f1 = blend(c[0][1][0], c[1][1][0], fx);
      b0 = blend(c[0][0][1], c[1][0][1], fx);
      b1 = blend(c[0][1][1], c[1][1][1], fx);
      v[i] = blend(blend(f0, f1, fy), blend(b0, b1, fy), fz);
    end
    return VALUE_BITS'(blend(v[0], v[1], ft));
  endfunction

  task automatic send_request(logic act, logic [IDX_W-1:0] idx, logic [VALUE_BITS-1:0] nv,
                              logic [IDX_W-1:0] pv, logic [COORD_W-1:0] x,
                              logic [COORD_W-1:0] y, logic [COORD_W-1:0] z,
                              logic [TIME_W-1:0] t);
    int gap;
    gap = $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    load_index <= idx;
    load_noise <= nv;
    load_perm <= pv;
    coord_x <= x;
    coord_y <= y;
    coord_z <= z;
    coord_t <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (act == ACT_LOAD) begin
      noise_tbl[idx] = nv;
      perm_tbl[idx] = pv;
      n_loads++;
    end else begin
      noise_due.push_back(noise_at(x, y, z, t));
      n_queries++;
    end
  endtask

  task automatic load_entry(int k, logic [VALUE_BITS-1:0] nv, logic [IDX_W-1:0] pv);
    send_request(ACT_LOAD, IDX_W'(k), nv, pv, $urandom, $urandom, $urandom,
                 {$urandom, $urandom});
  endtask

  task automatic query(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                       logic [COORD_W-1:0] z, logic [TIME_W-1:0] t);
    send_request(ACT_QUERY, $urandom, $urandom, $urandom, x, y, z, t);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (noise_due.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  // Every entry is written before any query so that no unwritten entry is read.
  task automatic test_fill_tables();
    for (int k = 0; k < TABLE_SIZE; k++) begin
      logic [VALUE_BITS-1:0] nv;
      nv = $urandom;
      if (k == 0) nv = 16'h8000;
      if (k == 1) nv = 16'h7FFF;
      load_entry(k, nv, $urandom);
    end
  endtask

  task automatic test_extremes();
    query(32'h0, 32'h0, 32'h0, 48'h0);
    query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF);
    query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 48'h8000_0000_0000);
    query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    query(32'h00FF_FFFF, 32'h00FF_8000, 32'hFFFF_0001, 48'h0000_00FF_C000);
    query(32'hFFFF_8000, 32'h0001_0000, 32'h00FF_0000, 48'hFFFF_FFFF_0000);
    // Max spread between neighbors: entries 0 and 1 hold the two extremes.
    for (int k = 0; k < 4; k++) load_entry(k, k[0] ? 16'h7FFF : 16'h8000, IDX_W'(k));
    load_entry(255, 16'h7FFF, 8'hFF);
    query(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 48'h0000_0000_FFFF);
    query(32'h0000_0001, 32'h0000_8000, 32'hFFFF_FFFF, 48'h0000_0000_0001);
  endtask

  task automatic test_random_mix();
    for (int n = 0; n < 115; n++) begin
      if ($urandom_range(0, 3) == 0)
        load_entry($urandom_range(0, 255), $urandom, $urandom);
      else if ($urandom_range(0, 4) == 0)
        query($urandom, $urandom, $urandom, {$urandom, $urandom});
      else
        query({16'($urandom_range(0, 3)), 16'($urandom)},
              {16'($urandom_range(0, 3)), 16'($urandom)},
              {16'($urandom_range(0, 3)), 16'($urandom)},
              {32'($urandom_range(0, 3)), 16'($urandom)});
    end
  endtask

  // Result side: random stall per result, with a stretch of no stalls.
  initial begin
    forever begin
      int wait_cycles;
      @(posedge clk);
      if (!stall_free && !rst) begin
        wait_cycles = $urandom_range(0, 13);
        if (wait_cycles > 0) begin
          out_stall <= 1'b1;
          repeat (wait_cycles) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (noise_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time, noise_out);
        errors++;
      end else begin
        logic signed [VALUE_BITS-1:0] want;
        want = noise_due.pop_front();
        if (noise_out !== want) begin
          $display("%0t: noise_out mismatch, expected %0d, actual %0d", $time, want,
                   noise_out);
          errors++;
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fill_tables();
    test_extremes();
    stall_free = 1'b1;
    test_random_mix();
    stall_free = 1'b0;
    test_random_mix();
    drain();
    repeat (400) @(posedge clk);
    $display("Ran %0d table loads and %0d noise queries; %0d results checked.",
             n_loads, n_queries, n_results);
    if (errors == 0 && noise_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("Failures: %0d, results still missing: %0d", errors, noise_due.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
src/vn4_pkg.sv
src/vn4_ram.sv
src/vn4_front.sv
src/vn4_back.sv
src/value_noise_4d.sv
dv/tb_top.sv
